/* rtl/core/soc_pkg.sv */
// Shared types and sizes for the substring occurrence counter.
// No dependencies; every other file of the block refers to it by scoped names.
package soc_pkg;

    localparam int PATTERN_MAX = 64;   // pattern bytes held, one per cell
    localparam int COUNT_BITS  = 10;   // width of the saturating match counter
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int MCOUNT_W    = 10;   // width of the match_count result field

    typedef enum logic [1:0] {
        CMD_PAT_APPEND = 2'd0,
        CMD_TEXT       = 2'd1,
        CMD_END        = 2'd2,
        CMD_PAT_CLEAR  = 2'd3
    } t_cmd;

    // per-cycle controls broadcast to every cell of the chain
    typedef struct packed {
        logic pat_shift;   // push a pattern byte in at cell 0
        logic pat_clear;   // drop the whole pattern
        logic txt_shift;   // push a text byte in at cell 0
        logic txt_clear;   // start a fresh text
    } t_cell_ctl;

endpackage

/* rtl/core/soc_cell.sv */
// One cell of the compare chain: a pattern byte and a text byte, each with a
// valid bit, handed on to the next cell when shifted. Uses soc_pkg.
module soc_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  soc_pkg::t_cell_ctl    i_ctl,
    input  logic [7:0]            i_pat_byte,
    input  logic                  i_pat_vld,
    input  logic [7:0]            i_txt_byte,
    input  logic                  i_txt_vld,
    output logic [7:0]            o_pat_byte,
    output logic                  o_pat_vld,
    output logic [7:0]            o_txt_byte,
    output logic                  o_txt_vld,
    output logic                  o_eq
);

    logic [7:0] r_pat_byte;
    logic       r_pat_vld;
    logic [7:0] r_txt_byte;
    logic       r_txt_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_vld <= 1'b0;
            r_txt_vld <= 1'b0;
        end else begin
            if (i_ctl.pat_clear) begin
                r_pat_vld <= 1'b0;
            end else if (i_ctl.pat_shift) begin
                r_pat_vld <= i_pat_vld;
            end
            if (i_ctl.txt_clear) begin
                r_txt_vld <= 1'b0;
            end else if (i_ctl.txt_shift) begin
                r_txt_vld <= i_txt_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_shift) begin
            r_pat_byte <= i_pat_byte;
        end
        if (i_ctl.txt_shift) begin
            r_txt_byte <= i_txt_byte;
        end
    end

    // compare against the window as it stands after the incoming byte shifts in;
    // a cell beyond the pattern end always agrees
    assign o_eq       = !r_pat_vld || (i_txt_vld && (i_txt_byte == r_pat_byte));
    assign o_pat_byte = r_pat_byte;
    assign o_pat_vld  = r_pat_vld;
    assign o_txt_byte = r_txt_byte;
    assign o_txt_vld  = r_txt_vld;

endmodule

/* rtl/core/substring_occurrence_counter.sv */
// Top level of the non-overlapping substring counter: chain of soc_cell
// instances, skip/count control and the result register. Uses soc_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  input   | in        | i_valid / o_stall  | i_command, i_data_byte
//  result  | out       | o_valid / i_stall  | o_match_count, o_match_here,
//          |           |                    | o_text_done
//
// One item per cycle while o_stall is low: the whole window is compared by the
// cell chain in the cycle a text byte transfers, and the result lands in the
// output register. Reset is synchronous; no clearing pass is needed.
// o_stall rises only while a result is held and the output side stalls.
module substring_occurrence_counter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_command,
    input  logic [7:0]                   i_data_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [soc_pkg::MCOUNT_W-1:0] o_match_count,
    output logic                         o_match_here,
    output logic                         o_text_done
);

    localparam int N   = soc_pkg::PATTERN_MAX;
    localparam int LW  = soc_pkg::LEN_W;
    localparam int CW  = soc_pkg::COUNT_BITS;
    localparam int MW  = soc_pkg::MCOUNT_W;

    soc_pkg::t_cmd       cmd;
    soc_pkg::t_cell_ctl  ctl;
    logic                accept;
    logic                is_text;
    logic                is_end;
    logic                pat_full;
    logic                hit;
    logic                load_out;

    logic [7:0]          pat_byte [N+1];
    logic                pat_vld  [N+1];
    logic [7:0]          txt_byte [N+1];
    logic                txt_vld  [N+1];
    logic [N-1:0]        eq;

    logic [LW-1:0]       r_pat_len, n_pat_len;
    logic [LW-1:0]       r_skip, n_skip;
    logic [CW-1:0]       r_count, n_count;
    logic [CW+MW-1:0]    count_ext;
    logic                r_out_valid;
    logic [MW-1:0]       r_out_count;
    logic                r_out_here;
    logic                r_out_done;

    assign cmd     = soc_pkg::t_cmd'(i_command);
    assign accept  = i_valid && !o_stall;
    assign is_text = accept && (cmd == soc_pkg::CMD_TEXT);
    assign is_end  = accept && (cmd == soc_pkg::CMD_END);
    assign pat_full = pat_vld[N];

    always_comb begin
        ctl.pat_shift = accept && (cmd == soc_pkg::CMD_PAT_APPEND) && !pat_full;
        ctl.pat_clear = accept && (cmd == soc_pkg::CMD_PAT_CLEAR);
        ctl.txt_shift = is_text;
        ctl.txt_clear = is_end;
    end

    assign pat_byte[0] = i_data_byte;
    assign pat_vld[0]  = 1'b1;
    assign txt_byte[0] = i_data_byte;
    assign txt_vld[0]  = 1'b1;

    for (genvar k = 0; k < N; k++) begin : g_cell
        soc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_pat_byte (pat_byte[k]),
            .i_pat_vld  (pat_vld[k]),
            .i_txt_byte (txt_byte[k]),
            .i_txt_vld  (txt_vld[k]),
            .o_pat_byte (pat_byte[k+1]),
            .o_pat_vld  (pat_vld[k+1]),
            .o_txt_byte (txt_byte[k+1]),
            .o_txt_vld  (txt_vld[k+1]),
            .o_eq       (eq[k])
        );
    end

    // an empty pattern leaves cell 0 invalid and never matches
    assign hit = is_text && (r_skip == '0) && pat_vld[1] && (&eq);

    always_comb begin
        n_pat_len = r_pat_len;
        n_skip    = r_skip;
        n_count   = r_count;
        if (accept) begin
            case (cmd)
                soc_pkg::CMD_PAT_APPEND: begin
                    if (!pat_full) begin
                        n_pat_len = r_pat_len + LW'(1);
                    end
                end
                soc_pkg::CMD_PAT_CLEAR: begin
                    n_pat_len = '0;
                    n_skip    = '0;
                end
                soc_pkg::CMD_END: begin
                    n_skip  = '0;
                    n_count = '0;
                end
                soc_pkg::CMD_TEXT: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - LW'(1);
                    end else if (hit) begin
                        n_skip = r_pat_len - LW'(1);
                        if (r_count != '1) begin
                            n_count = r_count + CW'(1);
                        end
                    end
                end
                default: begin
                    n_skip = r_skip;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            r_skip    <= '0;
            r_count   <= '0;
        end else begin
            r_pat_len <= n_pat_len;
            r_skip    <= n_skip;
            r_count   <= n_count;
        end
    end

    // report the count after this byte, or the final count on end of text
    assign load_out  = is_text || is_end;
    assign count_ext = (CW+MW)'(is_end ? r_count : n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_count <= count_ext[MW-1:0];
            r_out_here  <= hit;
            r_out_done  <= is_end;
        end
    end

    // hold input while a result waits on a stalled output
    assign o_stall       = r_out_valid && i_stall;
    assign o_valid       = r_out_valid;
    assign o_match_count = r_out_count;
    assign o_match_here  = r_out_here;
    assign o_text_done   = r_out_done;

    a_skip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip == '0) || (r_skip < r_pat_len))
        else $error("skip count reaches past the pattern length");

    a_hit_arms_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |=> (r_skip == $past(r_pat_len) - LW'(1)))
        else $error("match did not load the skip count");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_end |=> (r_count == '0) && (r_skip == '0) && o_valid && o_text_done
                   && !o_match_here)
        else $error("end of text did not report and clear");

endmodule
